### rtl/dscr_pkg.sv
package dscr_pkg;

    typedef enum logic [2:0] {
        KIND_CMD_READ  = 3'd0,
        KIND_DATA_READ = 3'd1,
        KIND_CMD_WRITE = 3'd2,
        KIND_DATA_WRITE = 3'd3,
        KIND_RX_BYTE   = 3'd4
    } kind_t;

    // Register pointer values that hold state other logic looks at
    localparam logic [3:0] PTR_WR0  = 4'd0;
    localparam logic [3:0] PTR_WR3  = 4'd3;
    localparam logic [3:0] PTR_WR14 = 4'd14;

    // Character length codes in WR3 bits 7:6
    localparam logic [1:0] LEN_5 = 2'b00;
    localparam logic [1:0] LEN_7 = 2'b01;
    localparam logic [1:0] LEN_6 = 2'b10;

    localparam logic [7:0] WR0_KEEP_MASK = 8'hf0;
    localparam logic [7:0] RR0_BASE      = 8'h04;
    localparam int unsigned NUM_CHANNELS = 2;

    // Per-channel state kept in one memory word
    typedef struct packed {
        logic [7:0] wr0;
        logic [1:0] wr3_len;
        logic       loopback;
        logic       rx_avail;
        logic [7:0] rx_latch;
    } chan_state_t;

endpackage

### rtl/dscr_req_if.sv
interface dscr_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       channel;
    logic [7:0] value;
    logic       serial_inhibit;

    modport source (output valid, output kind, output channel, output value,
                    output serial_inhibit, input ready);
    modport sink (input valid, input kind, input channel, input value,
                  input serial_inhibit, output ready);
endinterface

### rtl/dscr_rsp_if.sv
interface dscr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [6:0] tx_char;

    modport source (output valid, output read_data, output tx_valid, output tx_char,
                    input ready);
    modport sink (input valid, input read_data, input tx_valid, input tx_char,
                  output ready);
endinterface

### rtl/dscr_ram.sv
module dscr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/dual_serial_controller_registers_top.sv
// Channel | Dir | Payload                                | Transaction
// req     | in  | kind, channel, value, serial_inhibit   | valid && ready
// rsp     | out | read_data, tx_valid, tx_char           | valid && ready
//
// One transaction per cycle sustained while rsp is ready. The read stage
// reads the channel's state word from a two-entry RAM; the update stage
// modifies it, writes it back and loads the output register. Back-to-back
// accesses to one channel take the written word from a bypass register.
// Reset clears the entry valid bits; an unwritten entry reads as zero.
// A stalled rsp holds the output register and the update stage, then req.
module dual_serial_controller_registers_top
    import dscr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dscr_req_if.sink   req,
    dscr_rsp_if.source rsp
);

    localparam int SW = $bits(chan_state_t);

    logic              s1_valid_reg;
    logic [2:0]        s1_kind_reg;
    logic              s1_ch_reg;
    logic [7:0]        s1_value_reg;
    logic              s1_inhibit_reg;
    logic              rd_valid_reg;
    logic              fwd_hit_reg;
    chan_state_t       fwd_state_reg;
    logic [NUM_CHANNELS-1:0] ent_valid_reg;

    logic              out_valid_reg;
    logic [7:0]        rd_data_reg;
    logic              tx_valid_reg;
    logic [6:0]        tx_char_reg;

    logic              in_fire;
    logic              s1_advance;
    logic              commit;
    logic [SW-1:0]     ram_rdata;
    chan_state_t       cur;
    chan_state_t       nxt;
    logic [3:0]        ptr;
    logic [7:0]        len_mask;
    logic [7:0]        rd;
    logic              txv;
    logic [6:0]        txc;

    assign s1_advance = !out_valid_reg || rsp.ready;
    assign commit     = s1_valid_reg && s1_advance;
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign in_fire    = req.valid && req.ready;

    dscr_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .re    (in_fire),
        .raddr (req.channel),
        .rdata (ram_rdata),
        .we    (commit),
        .waddr (s1_ch_reg),
        .wdata (nxt)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur = fwd_state_reg;
        end
        else if (rd_valid_reg)
        begin
            cur = chan_state_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    // Pointer is WR0[2:0], plus 8 when WR0[5:3] is 001
    assign ptr = {(cur.wr0[5:3] == 3'b001), cur.wr0[2:0]};

    always_comb
    begin
        case (cur.wr3_len)
            LEN_5:   len_mask = 8'h1f;
            LEN_7:   len_mask = 8'h7f;
            LEN_6:   len_mask = 8'h3f;
            default: len_mask = 8'hff;
        endcase
    end

    always_comb
    begin
        nxt = cur;
        rd  = '0;
        txv = 1'b0;
        txc = '0;
        case (s1_kind_reg)
            KIND_CMD_READ:
            begin
                nxt.wr0 = cur.wr0 & WR0_KEEP_MASK;
                if (ptr == PTR_WR0)
                begin
                    rd = RR0_BASE | {7'd0, cur.rx_avail};
                end
            end
            KIND_DATA_READ:
            begin
                if (cur.rx_avail)
                begin
                    nxt.rx_avail = 1'b0;
                    rd           = cur.rx_latch;
                end
            end
            KIND_CMD_WRITE:
            begin
                nxt.wr0 = cur.wr0 & WR0_KEEP_MASK;
                if (!(ptr == PTR_WR0 && s1_value_reg == 8'd0))
                begin
                    if (ptr == PTR_WR0)
                    begin
                        nxt.wr0 = s1_value_reg;
                    end
                    if (ptr == PTR_WR3)
                    begin
                        nxt.wr3_len = s1_value_reg[7:6];
                    end
                    if (ptr == PTR_WR14)
                    begin
                        nxt.loopback = s1_value_reg[4];
                    end
                end
            end
            KIND_DATA_WRITE:
            begin
                if (cur.loopback)
                begin
                    nxt.rx_latch = s1_value_reg & len_mask;
                    nxt.rx_avail = 1'b1;
                end
                else if (!s1_inhibit_reg)
                begin
                    txv = 1'b1;
                    txc = s1_value_reg[6:0];
                end
            end
            KIND_RX_BYTE:
            begin
                if (!cur.loopback && !s1_inhibit_reg)
                begin
                    nxt.rx_latch = s1_value_reg;
                    nxt.rx_avail = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                rd_valid_reg <= ent_valid_reg[req.channel];
                // Bypass the word written on the same edge as this read
                fwd_hit_reg  <= commit && (s1_ch_reg == req.channel);
            end
            else if (commit)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                ent_valid_reg[s1_ch_reg] <= 1'b1;
                out_valid_reg            <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg    <= req.kind;
            s1_ch_reg      <= req.channel;
            s1_value_reg   <= req.value;
            s1_inhibit_reg <= req.serial_inhibit;
        end
        if (commit)
        begin
            fwd_state_reg <= nxt;
            rd_data_reg   <= rd;
            tx_valid_reg  <= txv;
            tx_char_reg   <= txc;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = rd_data_reg;
    assign rsp.tx_valid  = tx_valid_reg;
    assign rsp.tx_char   = tx_char_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dscr_pkg::*;

    localparam int          CHAN_REGS        = 16;
    localparam int          NUM_ITEMS        = 1100;
    localparam int          LONG_HOLD_CYCLES = 64;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int          MAX_REPORTS      = 10;
    localparam int          HOLD_AT_ITEM     = 300;
    localparam int          PAUSE_AT_ITEM    = 650;
    localparam logic [2:0]  PTR_HIGH_BANK    = 3'b001;
    localparam int          LOOPBACK_BIT     = 4;

    typedef struct packed {
        logic [2:0] kind;
        logic       channel;
        logic [7:0] value;
        logic       serial_inhibit;
    } access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [6:0] tx_char;
    } rsp_item_t;

    class serial_regs_scoreboard;
        logic [7:0] wr_file [2 * CHAN_REGS];
        logic       rx_avail [NUM_CHANNELS];
        logic [7:0] rx_byte [NUM_CHANNELS];
        rsp_item_t  expected_q [$];
        int         mismatches;

        function new();
            foreach (wr_file[i]) wr_file[i] = '0;
            foreach (rx_avail[i]) rx_avail[i] = 1'b0;
            foreach (rx_byte[i]) rx_byte[i] = '0;
            mismatches = 0;
        endfunction

        function logic [3:0] pointer_of(logic ch);
            logic [7:0] w0;
            logic [3:0] p;
            w0 = wr_file[{ch, PTR_WR0}];
            p = {1'b0, w0[2:0]};
            if (w0[5:3] == PTR_HIGH_BANK)
                p = p + 4'd8;
            return p;
        endfunction

        function bit loopback_on(logic ch);
            return wr_file[{ch, PTR_WR14}][LOOPBACK_BIT];
        endfunction

        function void note_request(access_t a);
            rsp_item_t  r;
            logic [3:0] p;
            logic [7:0] v;
            logic       ch;
            r  = '0;
            ch = a.channel;
            v  = a.value;
            case (a.kind)
                KIND_CMD_READ:
                begin
                    p = pointer_of(ch);
                    wr_file[{ch, PTR_WR0}] = wr_file[{ch, PTR_WR0}] & WR0_KEEP_MASK;
                    if (p == PTR_WR0)
                        r.read_data = RR0_BASE | {7'b0, rx_avail[ch]};
                end
                KIND_DATA_READ:
                begin
                    if (rx_avail[ch])
                    begin
                        rx_avail[ch] = 1'b0;
                        r.read_data = rx_byte[ch];
                    end
                end
                KIND_CMD_WRITE:
                begin
                    p = pointer_of(ch);
                    wr_file[{ch, PTR_WR0}] = wr_file[{ch, PTR_WR0}] & WR0_KEEP_MASK;
                    if (!(p == PTR_WR0 && v == 8'h00))
                        wr_file[{ch, p}] = v;
                end
                KIND_DATA_WRITE:
                begin
                    if (loopback_on(ch))
                    begin
                        case (wr_file[{ch, PTR_WR3}][7:6])
                            LEN_5: v = v & 8'h1f;
                            LEN_7: v = v & 8'h7f;
                            LEN_6: v = v & 8'h3f;
                            default: ;
                        endcase
                        rx_byte[ch]  = v;
                        rx_avail[ch] = 1'b1;
                    end
                    else if (!a.serial_inhibit)
                    begin
                        r.tx_valid = 1'b1;
                        r.tx_char  = v[6:0];
                    end
                end
                KIND_RX_BYTE:
                begin
                    if (!loopback_on(ch) && !a.serial_inhibit)
                    begin
                        rx_byte[ch]  = v;
                        rx_avail[ch] = 1'b1;
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected response: rd=%h tx_valid=%b tx_char=%h",
                             got.read_data, got.tx_valid, got.tx_char);
                return;
            end
            want = expected_q.pop_front();
            if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
                got.tx_char !== want.tx_char)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $write("mismatch: expected rd=%h tx_valid=%b tx_char=%h,",
                           want.read_data, want.tx_valid, want.tx_char);
                    $display(" got rd=%h tx_valid=%b tx_char=%h",
                             got.read_data, got.tx_valid, got.tx_char);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dscr_req_if req_if ();
    dscr_rsp_if rsp_if ();

    dual_serial_controller_registers_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    serial_regs_scoreboard sb;
    int n_sent;
    int tight_left;
    bit long_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic access_t mk(logic [2:0] kind, logic ch, logic [7:0] v, logic inh);
        access_t a;
        a.kind           = kind;
        a.channel        = ch;
        a.value          = v;
        a.serial_inhibit = inh;
        return a;
    endfunction

    // WR0 byte that points the next command access at reg_idx
    function automatic logic [7:0] point_at(logic [3:0] reg_idx, bit plain);
        logic [2:0] mid;
        logic [1:0] top;
        top = plain ? 2'b00 : 2'($urandom_range(0, 3));
        mid = plain ? 3'b000 : 3'($urandom_range(0, 7));
        if (reg_idx[3])
            mid = PTR_HIGH_BANK;
        else if (mid == PTR_HIGH_BANK)
            mid = 3'b000;
        return {top, mid, reg_idx[2:0]};
    endfunction

    task automatic send_access(access_t a, bit tight);
        int gap;
        req_if.valid          <= 1'b1;
        req_if.kind           <= a.kind;
        req_if.channel        <= a.channel;
        req_if.value          <= a.value;
        req_if.serial_inhibit <= a.serial_inhibit;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(a);
        n_sent++;
        gap = (tight || tight_left > 0 || long_hold) ? 0 : idle_gap();
        if (tight_left > 0)
            tight_left--;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        int k;
        send_access(mk(KIND_CMD_READ, 1'b0, 8'h00, 1'b0), 1'b0);
        // pointer 0 with value 0 stores nothing
        send_access(mk(KIND_CMD_WRITE, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, point_at(PTR_WR3, 1'b1), 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, 8'hc0, 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, point_at(PTR_WR14, 1'b1), 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, 8'h10, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_WRITE, 1'b0, 8'hff, 1'b1), 1'b0);
        send_access(mk(KIND_CMD_READ, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_READ, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_READ, 1'b0, 8'hff, 1'b0), 1'b0);
        // received byte is dropped in loopback
        send_access(mk(KIND_RX_BYTE, 1'b0, 8'h55, 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, point_at(PTR_WR3, 1'b1), 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_WRITE, 1'b0, 8'hff, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_READ, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, point_at(PTR_WR14, 1'b1), 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_WRITE, 1'b0, 8'hff, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_WRITE, 1'b0, 8'h80, 1'b1), 1'b0);
        send_access(mk(KIND_RX_BYTE, 1'b0, 8'ha5, 1'b0), 1'b0);
        // overwrite the waiting byte, then drop an inhibited one
        send_access(mk(KIND_RX_BYTE, 1'b0, 8'h5a, 1'b0), 1'b0);
        send_access(mk(KIND_RX_BYTE, 1'b0, 8'hff, 1'b1), 1'b0);
        send_access(mk(KIND_DATA_READ, 1'b0, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_RX_BYTE, 1'b1, 8'h81, 1'b0), 1'b0);
        send_access(mk(KIND_CMD_WRITE, 1'b1, point_at(4'd13, 1'b0), 1'b1), 1'b0);
        send_access(mk(KIND_CMD_READ, 1'b1, 8'h00, 1'b0), 1'b0);
        send_access(mk(KIND_DATA_READ, 1'b1, 8'h00, 1'b0), 1'b0);
        for (k = int'(KIND_RX_BYTE) + 1; k < 8; k++)
            send_access(mk(3'(k), k[0], 8'hff, 1'b0), 1'b0);
    endtask

    task automatic run_sequence(bit tight);
        int         pick;
        int         sel;
        logic       ch;
        logic       inh;
        logic [7:0] v;
        logic [3:0] target;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        ch   = 1'($urandom_range(0, 1));
        inh  = ($urandom_range(0, 3) == 0);
        v    = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        if (sel < 3)
            target = PTR_WR3;
        else if (sel < 6)
            target = PTR_WR14;
        else if (sel == 6)
            target = PTR_WR0;
        else
            target = 4'($urandom_range(0, 15));
        if (pick < 35)
        begin
            send_access(mk(KIND_CMD_WRITE, ch, point_at(target, 1'b0), inh), tight);
            send_access(mk(KIND_CMD_WRITE, ch, v, inh), tight);
        end
        else if (pick < 45)
        begin
            if (sel < 5)
                target = PTR_WR0;
            send_access(mk(KIND_CMD_WRITE, ch, point_at(target, 1'b0), inh), tight);
            send_access(mk(KIND_CMD_READ, ch, v, inh), tight);
        end
        else if (pick < 65)
            send_access(mk(KIND_DATA_WRITE, ch, v, inh), tight);
        else if (pick < 80)
            send_access(mk(KIND_DATA_READ, ch, v, inh), tight);
        else if (pick < 90)
            send_access(mk(KIND_RX_BYTE, ch, v, inh), tight);
        else
            send_access(mk(3'($urandom_range(0, 7)), ch, 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1))), tight);
    endtask

    // response side: random ready with one long hold-off on request
    initial
    begin
        int on_len;
        int gap;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            on_len = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
            rsp_if.ready <= 1'b1;
            repeat (on_len) @(posedge clk);
            if (long_hold)
            begin
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response({rsp_if.read_data, rsp_if.tx_valid, rsp_if.tx_char});
        end
    end

    initial
    begin
        bit did_hold;
        bit did_pause;
        bit seg_tight;
        int seg_end;
        sb         = new();
        n_sent     = 0;
        tight_left = 0;
        long_hold  = 1'b0;
        did_hold   = 1'b0;
        did_pause  = 1'b0;
        seg_tight  = 1'b0;
        seg_end    = 0;
        rst_n                 <= 1'b0;
        req_if.valid          <= 1'b0;
        req_if.kind           <= KIND_CMD_READ;
        req_if.channel        <= 1'b0;
        req_if.value          <= 8'h00;
        req_if.serial_inhibit <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        while (n_sent < NUM_ITEMS)
        begin
            if (n_sent >= seg_end)
            begin
                seg_tight = ($urandom_range(0, 3) == 0);
                seg_end   = n_sent + $urandom_range(30, 80);
            end
            // keep offering back to back while the response side holds off
            if (!did_hold && n_sent >= HOLD_AT_ITEM)
            begin
                did_hold   = 1'b1;
                long_hold  = 1'b1;
                tight_left = 80;
            end
            if (!did_pause && n_sent >= PAUSE_AT_ITEM)
            begin
                did_pause = 1'b1;
                req_if.valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            run_sequence(seg_tight);
        end

        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### dual_serial_controller_registers_top.f
rtl/dscr_pkg.sv
rtl/dscr_req_if.sv
rtl/dscr_rsp_if.sv
rtl/dscr_ram.sv
rtl/dual_serial_controller_registers_top.sv
dv/tb_top.sv
